@@ src/xrs_pkg.sv @@
// ----------------------------------------------------------------------------
// xrs_pkg
// Shared types and constants of the rejection sampler mod q.
// ----------------------------------------------------------------------------
package xrs_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ModW    = 17;
  localparam int unsigned SpoW    = 20;
  localparam int unsigned AccW    = 24;
  localparam int unsigned HeldW   = 5;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // depth of the result queue between front and output
  localparam int unsigned QueueDepth = 2;

  // register reset values
  localparam logic [1:0]      WidthModeRst = 2'd2;
  localparam logic [ModW-1:0] ModulusRst   = 17'd4093;
  localparam logic [SpoW-1:0] SpoRst       = 20'd1;

  // chunk width modes
  typedef enum logic [1:0] {
    MODE_W8  = 2'd0,
    MODE_W10 = 2'd1,
    MODE_W12 = 2'd2,
    MODE_W16 = 2'd3
  } width_mode_e;

  // register word index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_WIDTH_MODE = 2'd0,
    REG_MODULUS    = 2'd1,
    REG_SPO        = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    width_mode_e     width_mode;
    logic [ModW-1:0] modulus;
    logic [SpoW-1:0] samples_per_object;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } result_t;

  // chunk width in bits for a mode
  function automatic logic [HeldW-1:0] chunk_width(input width_mode_e mode);
    logic [HeldW-1:0] w;
    unique case (mode)
      MODE_W8:  w = 5'd8;
      MODE_W10: w = 5'd10;
      MODE_W12: w = 5'd12;
      default:  w = 5'd16;
    endcase
    return w;
  endfunction

endpackage

@@ src/xof_rejection_sampler_mod_q.sv @@
// ----------------------------------------------------------------------------
// xof_rejection_sampler_mod_q
// Uniform sampler mod q over an extendable-output byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a byte beat on xof_byte_i is taken at
//   a clock edge with push high and full low. Bits are read LSB first; each
//   byte yields at most one chunk of 8, 10, 12 or 16 bits.
//   Result side is a queue read port: while empty is low, sample_o/last_o
//   show the oldest result, which leaves at an edge with pop high.
//   A result is queued at the edge that takes its byte beat and is visible after it.
//   Throughput: one byte per cycle while full is low; packer, chunk compare
//   and object counter are combinational, so bytes may come back to back.
//   A two-entry result queue decouples the sides; if pop stays low the
//   queue fills and full rises, holding off input until a result is taken.
//   Reset empties the queue, clears the bit accumulator and object counter,
//   and loads width mode 12 bits, modulus 4093 and one sample per object.
//   Configuration is written over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module xof_rejection_sampler_mod_q #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input
  input  logic                        push,
  output logic                        full,
  input  logic [xrs_pkg::ByteW-1:0]   xof_byte_i,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic [xrs_pkg::SampleW-1:0] sample_o,
  output logic                        last_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xrs_pkg::AddrW-1:0]   paddr,
  input  logic [xrs_pkg::DataW-1:0]   pwdata,
  output logic [xrs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import xrs_pkg::*;

  cfg_t    cfg;
  result_t res, head;
  logic    res_valid, byte_valid;

  assign byte_valid = push && !full;

  // configuration registers
  xrs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // packer and classifier
  xrs_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (byte_valid),
    .xof_byte_i   (xof_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result queue
  xrs_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i (res),
    .rd_i    (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  assign sample_o = head.sample;
  assign last_o   = head.last;

endmodule

@@ src/xrs_regs.sv @@
// ----------------------------------------------------------------------------
// xrs_regs
// APB-style configuration registers: chunk width mode, modulus and
// samples per object.
// ----------------------------------------------------------------------------
module xrs_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [xrs_pkg::AddrW-1:0] paddr,
  input  logic [xrs_pkg::DataW-1:0] pwdata,
  output logic [xrs_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output xrs_pkg::cfg_t             cfg_o
);
  import xrs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH_MODE: cfg_d.width_mode         = width_mode_e'(pwdata[1:0]);
        REG_MODULUS:    cfg_d.modulus            = pwdata[ModW-1:0];
        REG_SPO:        cfg_d.samples_per_object = pwdata[SpoW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_mode         <= width_mode_e'(WidthModeRst);
      cfg_q.modulus            <= ModulusRst;
      cfg_q.samples_per_object <= SpoRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_WIDTH_MODE: prdata = {{(DataW-2){1'b0}}, cfg_q.width_mode};
      REG_MODULUS:    prdata = {{(DataW-ModW){1'b0}}, cfg_q.modulus};
      REG_SPO:        prdata = {{(DataW-SpoW){1'b0}}, cfg_q.samples_per_object};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/xrs_front.sv @@
// ----------------------------------------------------------------------------
// xrs_front
// Bit packer and classifier: appends each byte to the bit accumulator,
// cuts one chunk, compares it to the modulus and counts accepted samples.
// ----------------------------------------------------------------------------
module xrs_front #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  xrs_pkg::cfg_t             cfg_i,
  input  logic                      byte_valid_i,
  input  logic [xrs_pkg::ByteW-1:0] xof_byte_i,
  output logic                      res_valid_o,
  output xrs_pkg::result_t          res_o
);
  import xrs_pkg::*;

  localparam int unsigned NextW = COUNT_BITS + 1;
  localparam int unsigned CmpW  = (NextW > SpoW) ? NextW : SpoW;

  logic [AccW-1:0]       acc_q, acc_d;
  logic [HeldW-1:0]      held_q, held_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic [AccW-1:0]    merged, rest;
  logic [HeldW-1:0]   held_sum, w;
  logic [SampleW-1:0] chunk;
  logic               have_chunk, take, is_last;
  logic [NextW-1:0]   next_cnt;

  // append the byte above the held bits
  assign merged   = acc_q | ({{(AccW-ByteW){1'b0}}, xof_byte_i} << held_q);
  assign held_sum = held_q + HeldW'(ByteW);
  assign w        = chunk_width(cfg_i.width_mode);
  assign have_chunk = (held_sum >= w);

  // lowest chunk and what stays behind
  always_comb begin
    case (cfg_i.width_mode)
      MODE_W8: begin
        chunk = {8'b0, merged[7:0]};
        rest  = {8'b0, merged[AccW-1:8]};
      end
      MODE_W10: begin
        chunk = {6'b0, merged[9:0]};
        rest  = {10'b0, merged[AccW-1:10]};
      end
      MODE_W12: begin
        chunk = {4'b0, merged[11:0]};
        rest  = {12'b0, merged[AccW-1:12]};
      end
      default: begin
        chunk = merged[15:0];
        rest  = {16'b0, merged[AccW-1:16]};
      end
    endcase
  end

  // acceptance and object count
  assign take     = have_chunk && ({1'b0, chunk} < cfg_i.modulus);
  assign next_cnt = {1'b0, cnt_q} + NextW'(1);
  assign is_last  = CmpW'(next_cnt) >= CmpW'(cfg_i.samples_per_object);

  // state update per accepted byte
  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    if (byte_valid_i) begin
      if (!have_chunk) begin
        acc_d  = merged;
        held_d = held_sum;
      end else if (take && is_last) begin
        acc_d  = '0;
        held_d = '0;
        cnt_d  = '0;
      end else begin
        acc_d  = rest;
        held_d = held_sum - w;
        if (take) begin
          cnt_d = next_cnt[COUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

  assign res_valid_o  = byte_valid_i && take;
  assign res_o.sample = chunk;
  assign res_o.last   = take && is_last;

endmodule

@@ src/xrs_queue.sv @@
// ----------------------------------------------------------------------------
// xrs_queue
// Small result queue between the classifier and the output; while neither
// full nor empty it takes a write and a read in the same cycle.
// ----------------------------------------------------------------------------
module xrs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  xrs_pkg::result_t wdata_i,
  input  logic             rd_i,
  output xrs_pkg::result_t rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  import xrs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ src/xrs_checker.sv @@
// ----------------------------------------------------------------------------
// xrs_checker
// Port-level checks of the sampler's queue behavior, bound to the top level.
// ----------------------------------------------------------------------------
module xrs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [xrs_pkg::SampleW-1:0] sample_o,
  input logic                        last_o
);

  // a full queue always holds a result
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full while empty");

  // a result only appears after a byte beat
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !full) |=> !$fell(empty))
    else $error("result appeared without a byte beat");

  // space only frees up when a result is taken
  a_full_drops_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && !empty) |=> !$fell(full))
    else $error("full dropped without a result beat");

  // a waiting result holds while stalled
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sample_o) && $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind xof_rejection_sampler_mod_q xrs_checker u_xrs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .sample_o (sample_o),
  .last_o   (last_o)
);
